@@ sv/assert_macros.svh @@
// assertion macros shared by the queue-of-stacks rtl
// clocked check and never-true check, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

@@ sv/cqs_pkg.sv @@
// package for the circular queue of stacks: sizes, codes, payload and control structs
// no dependencies
`default_nettype none
package cqs_pkg;

  localparam int unsigned QUEUE_SLOTS = 8;
  localparam int unsigned STACK_DEPTH = 16;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_ENQ  = 2'd2,
    CMD_DEQ  = 2'd3
  } cqs_cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STACK_FULL  = 3'd1,
    ST_STACK_EMPTY = 3'd2,
    ST_QUEUE_FULL  = 3'd3,
    ST_QUEUE_EMPTY = 3'd4
  } cqs_status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] push_value;
  } cqs_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] pop_value;
    logic [4:0]         stack_level;
    logic [2:0]         queue_level;
  } cqs_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        capture;
    logic        push;
    logic        pop;
    logic        enq_rd0;
    logic        enq_copy;
    logic        enq_commit;
    logic        deq_rd0;
    logic        deq_copy;
    logic        deq_commit;
    logic        load_out;
    cqs_status_e status;
  } cqs_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    cqs_cmd_e cmd;
    logic     stack_full;
    logic     stack_empty;
    logic     queue_full;
    logic     queue_empty;
    logic     enq_last;
    logic     deq_last;
    logic     len_zero;
    logic     out_free;
  } cqs_sts_t;

endpackage
`default_nettype wire

@@ sv/cqs_ctrl.sv @@
// controller state machine for the circular queue of stacks
// depends on cqs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cqs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cqs_pkg::cqs_sts_t sts_i,
  output cqs_pkg::cqs_ctl_t     ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ENQ_COPY,
    S_DEQ_LEN,
    S_DEQ_COPY,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  cqs_pkg::cqs_status_e status_q, status_d;

  // only the idle state takes a new transfer
  assign in_stall_o = (state_q != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ctl_o    = '0;
    ctl_o.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = cqs_pkg::ST_OK;
        state_d  = S_FINISH;
        case (sts_i.cmd)
          cqs_pkg::CMD_PUSH: begin
            if (sts_i.stack_full) status_d = cqs_pkg::ST_STACK_FULL;
            else ctl_o.push = 1'b1;
          end
          cqs_pkg::CMD_POP: begin
            if (sts_i.stack_empty) status_d = cqs_pkg::ST_STACK_EMPTY;
            else ctl_o.pop = 1'b1;
          end
          cqs_pkg::CMD_ENQ: begin
            if (sts_i.queue_full) begin
              status_d = cqs_pkg::ST_QUEUE_FULL;
            end else if (sts_i.stack_empty) begin
              ctl_o.enq_commit = 1'b1;
            end else begin
              ctl_o.enq_rd0 = 1'b1;
              state_d = S_ENQ_COPY;
            end
          end
          default: begin
            if (sts_i.queue_empty || !sts_i.stack_empty) begin
              status_d = cqs_pkg::ST_QUEUE_EMPTY;
            end else begin
              ctl_o.deq_rd0 = 1'b1;
              state_d = S_DEQ_LEN;
            end
          end
        endcase
      end
      S_ENQ_COPY: begin
        ctl_o.enq_copy = 1'b1;
        if (sts_i.enq_last) begin
          ctl_o.enq_commit = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_DEQ_LEN: begin
        if (sts_i.len_zero) begin
          ctl_o.deq_commit = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_DEQ_COPY;
        end
      end
      S_DEQ_COPY: begin
        ctl_o.deq_copy = 1'b1;
        if (sts_i.deq_last) begin
          ctl_o.deq_commit = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= cqs_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  `ASSERT_CLK(a_load_free, clk_i, rst_ni, ctl_o.load_out |-> sts_i.out_free)
  `ASSERT_CLK(a_accept_decode, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
  `ASSERT_CLK(a_pop_nonempty, clk_i, rst_ni, ctl_o.pop |-> !sts_i.stack_empty)

endmodule
`default_nettype wire

@@ sv/cqs_dp.sv @@
// datapath for the circular queue of stacks: working stack, slot memories,
// pointers, copy index and result register; depends on cqs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cqs_dp #(
  parameter int unsigned QUEUE_SLOTS = cqs_pkg::QUEUE_SLOTS,
  parameter int unsigned STACK_DEPTH = cqs_pkg::STACK_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cqs_pkg::cqs_in_t  in_data_i,
  input  wire cqs_pkg::cqs_ctl_t ctl_i,
  output cqs_pkg::cqs_sts_t     sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output cqs_pkg::cqs_out_t     out_data_o
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);

  // memories
  logic [31:0]      work_mem [STACK_DEPTH];
  logic [31:0]      slot_mem [QUEUE_SLOTS][STACK_DEPTH];
  logic [LVL_W-1:0] lvl_mem  [QUEUE_SLOTS];

  logic [31:0]      work_rdata_q;
  logic [31:0]      slot_rdata_q;
  logic [LVL_W-1:0] lvl_rdata_q;

  cqs_pkg::cqs_cmd_e cmd_q;
  logic [31:0]       val_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LVL_W-1:0]  work_level_q, work_level_d;
  logic [SLOT_W-1:0] front_q, rear_q;
  logic              out_valid_q;
  cqs_pkg::cqs_out_t out_q;

  logic [LVL_W-1:0]  lvl_m1;
  logic [IDX_W-1:0]  idx_p1;
  logic [LVL_W:0]    idx_ext_p1;
  logic [SLOT_W-1:0] rear_next, front_next;
  logic [SLOT_W:0]   count_raw;
  logic [SLOT_W-1:0] queue_count;
  logic              queue_full;

  logic              work_we, work_re, slot_re;
  logic [IDX_W-1:0]  work_waddr, work_raddr, slot_raddr;
  logic [31:0]       work_wdata;

  assign lvl_m1     = work_level_q - LVL_W'(1);
  assign idx_p1     = idx_q + IDX_W'(1);
  assign idx_ext_p1 = (LVL_W + 1)'(idx_q) + (LVL_W + 1)'(1);

  // circular pointer steps
  assign rear_next  = (rear_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : rear_q + SLOT_W'(1);
  assign front_next = (front_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : front_q + SLOT_W'(1);
  assign queue_full = (rear_next == front_q);

  // stored stack count, wrapping at the slot count
  always_comb begin
    count_raw = {1'b0, rear_q} - {1'b0, front_q};
    if (rear_q < front_q) begin
      count_raw = count_raw + (SLOT_W + 1)'(QUEUE_SLOTS);
    end
    queue_count = count_raw[SLOT_W-1:0];
  end

  // status to controller
  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.stack_full  = (work_level_q == LVL_W'(STACK_DEPTH));
    sts_o.stack_empty = (work_level_q == '0);
    sts_o.queue_full  = queue_full;
    sts_o.queue_empty = (front_q == rear_q);
    sts_o.enq_last    = (idx_ext_p1 == (LVL_W + 1)'(work_level_q));
    sts_o.deq_last    = (idx_ext_p1 == (LVL_W + 1)'(lvl_rdata_q));
    sts_o.len_zero    = (lvl_rdata_q == '0);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // working stack port selection
  assign work_we    = ctl_i.push || ctl_i.deq_copy;
  assign work_waddr = ctl_i.push ? work_level_q[IDX_W-1:0] : idx_q;
  assign work_wdata = ctl_i.push ? val_q : slot_rdata_q;
  assign work_re    = ctl_i.pop || ctl_i.enq_rd0 || ctl_i.enq_copy;
  assign work_raddr = ctl_i.pop ? lvl_m1[IDX_W-1:0] : (ctl_i.enq_copy ? idx_p1 : '0);
  assign slot_re    = ctl_i.deq_rd0 || ctl_i.deq_copy;
  assign slot_raddr = ctl_i.deq_copy ? idx_p1 : '0;

  // working stack memory
  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if (work_re) begin
      work_rdata_q <= work_mem[work_raddr];
    end
  end

  // slot item memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.enq_copy) begin
      slot_mem[rear_q][idx_q] <= work_rdata_q;
    end
    if (slot_re) begin
      slot_rdata_q <= slot_mem[front_q][slot_raddr];
    end
  end

  // slot level memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.enq_commit) begin
      lvl_mem[rear_q] <= work_level_q;
    end
    if (ctl_i.deq_rd0) begin
      lvl_rdata_q <= lvl_mem[front_q];
    end
  end

  // working level update
  always_comb begin
    work_level_d = work_level_q;
    if (ctl_i.push) begin
      work_level_d = work_level_q + LVL_W'(1);
    end else if (ctl_i.pop) begin
      work_level_d = lvl_m1;
    end else if (ctl_i.deq_commit) begin
      work_level_d = lvl_rdata_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_level_q <= '0;
      front_q      <= '0;
      rear_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      work_level_q <= work_level_d;
      if (ctl_i.enq_commit) rear_q <= rear_next;
      if (ctl_i.deq_commit) front_q <= front_next;
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= cqs_pkg::cqs_cmd_e'(in_data_i.command);
      val_q <= in_data_i.push_value;
    end
    if (ctl_i.enq_rd0 || ctl_i.deq_rd0) begin
      idx_q <= '0;
    end else if (ctl_i.enq_copy || ctl_i.deq_copy) begin
      idx_q <= idx_p1;
    end
    if (ctl_i.load_out) begin
      out_q.status      <= ctl_i.status;
      out_q.pop_value   <= (cmd_q == cqs_pkg::CMD_POP && ctl_i.status == cqs_pkg::ST_OK)
                           ? work_rdata_q : 32'd0;
      out_q.stack_level <= 5'(work_level_q);
      out_q.queue_level <= 3'(queue_count);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(a_level_range, clk_i, rst_ni, work_level_q > LVL_W'(STACK_DEPTH))
  `ASSERT_CLK(a_enq_room, clk_i, rst_ni, ctl_i.enq_commit |-> !queue_full)
  `ASSERT_CLK(a_front_hold, clk_i, rst_ni, !ctl_i.deq_commit |=> $stable(front_q))

endmodule
`default_nettype wire

@@ sv/circular_queue_of_stacks.sv @@
// circular queue of stacks: one working stack plus a ring of stored stacks.
// each command runs to its result before the next input transfer is taken; enqueue and
// dequeue copy the stack one item a cycle between the working stack and a slot.
// reset is asynchronous and active low: clears the working level, pointers and control; the
// item and level memories are not cleared and hold nothing until written.
`default_nettype none
module circular_queue_of_stacks #(
  parameter int unsigned QUEUE_SLOTS = cqs_pkg::QUEUE_SLOTS,
  parameter int unsigned STACK_DEPTH = cqs_pkg::STACK_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire cqs_pkg::cqs_in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output cqs_pkg::cqs_out_t out_data_o
);

  cqs_pkg::cqs_ctl_t ctl;
  cqs_pkg::cqs_sts_t sts;

  // sequencing of each command
  cqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // storage, pointers and result register
  cqs_dp #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
